@@ design/mpc_pkg.sv @@
// Shared constants, types and microcode table of the modulated phase clock.
package mpc_pkg;

   localparam int BASE_BITS     = 24;
   localparam int DEPTH_BITS    = 16;
   localparam int FMOD_BITS     = 16;
   localparam int OUT_STEP_BITS = 24;
   localparam int FRAC_BITS     = 27;
   localparam int FACTOR_BITS   = 32;
   localparam int REM_BITS      = FACTOR_BITS + 1;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 2;

   localparam logic [FACTOR_BITS-1:0] FACTOR_ONE = FACTOR_BITS'(64'd1 << FRAC_BITS);

   localparam logic [REG_IDX_BITS-1:0] REG_BASE_STEP  = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_MOD1_DEPTH = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_MOD2_DEPTH = 2'd2;

   localparam int OP_BITS   = 4;
   localparam int COND_BITS = 3;
   localparam int PC_BITS   = 4;

   typedef logic [OP_BITS-1:0]   op_type;
   typedef logic [COND_BITS-1:0] cond_type;
   typedef logic [PC_BITS-1:0]   pc_type;

   localparam op_type OP_IDLE    = 4'd0;
   localparam op_type OP_FACTOR  = 4'd1;
   localparam op_type OP_NOP     = 4'd2;
   localparam op_type OP_MUL     = 4'd3;
   localparam op_type OP_MULSAT  = 4'd4;
   localparam op_type OP_DIVINIT = 4'd5;
   localparam op_type OP_DIVSTEP = 4'd6;
   localparam op_type OP_DIVEND  = 4'd7;
   localparam op_type OP_SWITCH  = 4'd8;
   localparam op_type OP_FINISH  = 4'd9;

   localparam cond_type C_NEXT       = 3'd0;
   localparam cond_type C_ALWAYS     = 3'd1;
   localparam cond_type C_WAIT_IN    = 3'd2;
   localparam cond_type C_DEPTH_ZERO = 3'd3;
   localparam cond_type C_NEG        = 3'd4;
   localparam cond_type C_ITER_MORE  = 3'd5;
   localparam cond_type C_STAGE_A    = 3'd6;
   localparam cond_type C_OUT_BUSY   = 3'd7;

   localparam pc_type PC_IDLE    = 4'd0;
   localparam pc_type PC_FACTOR  = 4'd1;
   localparam pc_type PC_SIGN    = 4'd2;
   localparam pc_type PC_MUL     = 4'd3;
   localparam pc_type PC_MULSAT  = 4'd4;
   localparam pc_type PC_DIVINIT = 4'd5;
   localparam pc_type PC_DIVSTEP = 4'd6;
   localparam pc_type PC_DIVEND  = 4'd7;
   localparam pc_type PC_SWITCH  = 4'd8;
   localparam pc_type PC_FINISH  = 4'd9;
   localparam pc_type UCODE_LAST = PC_FINISH;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } ucode_type;

   typedef struct packed {
      logic wait_in;
      logic depth_zero;
      logic neg;
      logic iter_more;
      logic stage_a;
      logic out_busy;
   } status_type;

   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      case (pc)
         PC_IDLE:    w = '{OP_IDLE,    C_WAIT_IN,    PC_IDLE};
         PC_FACTOR:  w = '{OP_FACTOR,  C_DEPTH_ZERO, PC_SWITCH};
         PC_SIGN:    w = '{OP_NOP,     C_NEG,        PC_DIVINIT};
         PC_MUL:     w = '{OP_MUL,     C_NEXT,       PC_IDLE};
         PC_MULSAT:  w = '{OP_MULSAT,  C_ALWAYS,     PC_SWITCH};
         PC_DIVINIT: w = '{OP_DIVINIT, C_NEXT,       PC_IDLE};
         PC_DIVSTEP: w = '{OP_DIVSTEP, C_ITER_MORE,  PC_DIVSTEP};
         PC_DIVEND:  w = '{OP_DIVEND,  C_NEXT,       PC_IDLE};
         PC_SWITCH:  w = '{OP_SWITCH,  C_STAGE_A,    PC_FACTOR};
         PC_FINISH:  w = '{OP_FINISH,  C_OUT_BUSY,   PC_FINISH};
         default:    w = '{OP_NOP,     C_ALWAYS,     PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ design/mpc_if.sv @@
// Valid/ready channel interfaces for sample ticks and per-tick results.
interface mpc_req_if
   import mpc_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic                        phase_reset;
   logic signed [FMOD_BITS-1:0] fmod_a;
   logic signed [FMOD_BITS-1:0] fmod_b;

   modport source (output valid, output phase_reset, output fmod_a, output fmod_b,
                   input ready);
   modport sink (input valid, input phase_reset, input fmod_a, input fmod_b,
                 output ready);
endinterface

interface mpc_rsp_if
   import mpc_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     wrap_trigger;
   logic [OUT_STEP_BITS-1:0] phase_step;

   modport source (output valid, output wrap_trigger, output phase_step, input ready);
   modport sink (input valid, input wrap_trigger, input phase_step, output ready);
endinterface

@@ design/mpc_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module mpc_seq
   import mpc_pkg::*;
   (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output op_type     op
   );

   pc_type    pc_ff;
   pc_type    pc_in;
   ucode_type word;
   logic      taken;

   assign word = ucode_rom(pc_ff);
   assign op   = word.op;

   always_comb begin
      case (word.cond)
         C_NEXT:       taken = 1'b0;
         C_ALWAYS:     taken = 1'b1;
         C_WAIT_IN:    taken = status.wait_in;
         C_DEPTH_ZERO: taken = status.depth_zero;
         C_NEG:        taken = status.neg;
         C_ITER_MORE:  taken = status.iter_more;
         C_STAGE_A:    taken = status.stage_a;
         C_OUT_BUSY:   taken = status.out_busy;
         default:      taken = 1'b0;
      endcase
      if (taken) begin
         pc_in = word.target;
      end else if (pc_ff == UCODE_LAST) begin
         pc_in = PC_IDLE;
      end else begin
         pc_in = pc_ff + pc_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ design/modulated_phase_clock_top.sv @@
// Top level of the modulated phase clock: register port, datapath and result register.
// Phase accumulator with two chained frequency modulation stages, one result per tick.
// A stage whose modulation depth is zero is skipped; otherwise it multiplies the step when
// its modulation is positive or zero and divides it when the modulation is negative; the
// restoring divider retires one quotient bit per cycle.
// A new tick is taken while the previous result still waits to be transferred.
module modulated_phase_clock_top
   import mpc_pkg::*;
   #(
   parameter int PHASE_BITS = 24
   )
   (
   input  logic                     clock,
   input  logic                     reset,
   mpc_req_if.sink                  req_ch,
   mpc_rsp_if.source                rsp_ch,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
   );

   localparam int CNT_BITS   = $clog2(PHASE_BITS);
   localparam int DVD_BITS   = PHASE_BITS + FRAC_BITS;
   localparam int PROD_BITS  = PHASE_BITS + FACTOR_BITS;
   localparam int SHIFT_BITS = PROD_BITS - FRAC_BITS;
   localparam logic [PHASE_BITS-1:0] STEP_MAX   = '1;
   localparam logic [PHASE_BITS:0]   PHASE_INIT = {1'b1, {PHASE_BITS{1'b0}}};

   logic [BASE_BITS-1:0]        base_step_ff, base_step_in;
   logic [DEPTH_BITS-1:0]       mod1_depth_ff, mod1_depth_in;
   logic [DEPTH_BITS-1:0]       mod2_depth_ff, mod2_depth_in;
   logic [PHASE_BITS:0]         phase_ff, phase_in;
   logic [PHASE_BITS-1:0]       step_ff, step_in;
   logic signed [FMOD_BITS-1:0] fmod_a_ff, fmod_a_in;
   logic signed [FMOD_BITS-1:0] fmod_b_ff, fmod_b_in;
   logic                        phase_reset_ff, phase_reset_in;
   logic                        stage_ff, stage_in;
   logic [FACTOR_BITS-1:0]      factor_ff, factor_in;
   logic [PROD_BITS-1:0]        prod_ff, prod_in;
   logic [REM_BITS-1:0]         rem_ff, rem_in;
   logic [PHASE_BITS-1:0]       quot_ff, quot_in;
   logic [CNT_BITS-1:0]         count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        wrap_trigger_ff, wrap_trigger_in;
   logic [OUT_STEP_BITS-1:0]    phase_step_ff, phase_step_in;

   op_type                      op;
   status_type                  status;
   logic                        csr_write;
   logic [REG_IDX_BITS-1:0]     reg_idx;
   logic [DEPTH_BITS-1:0]       cur_depth;
   logic signed [FMOD_BITS-1:0] cur_fmod;
   logic                        cur_neg;
   logic [FMOD_BITS-1:0]        cur_mag;
   logic [PHASE_BITS+BASE_BITS-1:0]     base_wide;
   logic [PHASE_BITS-1:0]       base_sat;
   logic [SHIFT_BITS-1:0]       prod_shift;
   logic [PHASE_BITS-1:0]       mul_sat;
   logic [DVD_BITS-1:0]         dividend;
   logic [REM_BITS-1:0]         trial;
   logic                        trial_fits;
   logic [PHASE_BITS:0]         phase_sum;
   logic [PHASE_BITS+OUT_STEP_BITS-1:0] step_wide;
   logic                        out_busy;

   mpc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op)
   );

   assign csr_write = psel && penable && pwrite;
   assign reg_idx   = paddr[CSR_ADDR_BITS-1:2];
   assign pready    = 1'b1;

   always_comb begin
      case (reg_idx)
         REG_BASE_STEP:  prdata = CSR_DATA_BITS'(base_step_ff);
         REG_MOD1_DEPTH: prdata = CSR_DATA_BITS'(mod1_depth_ff);
         REG_MOD2_DEPTH: prdata = CSR_DATA_BITS'(mod2_depth_ff);
         default:        prdata = '0;
      endcase
   end

   assign cur_depth  = stage_ff ? mod2_depth_ff : mod1_depth_ff;
   assign cur_fmod   = stage_ff ? fmod_b_ff : fmod_a_ff;
   assign cur_neg    = cur_fmod[FMOD_BITS-1];
   assign cur_mag    = cur_neg ? FMOD_BITS'(-cur_fmod) : FMOD_BITS'(cur_fmod);

   assign base_wide  = {{PHASE_BITS{1'b0}}, base_step_ff};
   assign base_sat   = (base_wide > {{BASE_BITS{1'b0}}, STEP_MAX}) ?
                       STEP_MAX : base_wide[PHASE_BITS-1:0];

   assign prod_shift = prod_ff[PROD_BITS-1:FRAC_BITS];
   assign mul_sat    = (|prod_shift[SHIFT_BITS-1:PHASE_BITS]) ?
                       STEP_MAX : prod_shift[PHASE_BITS-1:0];

   assign dividend   = {step_ff, {FRAC_BITS{1'b0}}};
   assign trial      = {rem_ff[REM_BITS-2:0], quot_ff[PHASE_BITS-1]};
   assign trial_fits = trial >= {1'b0, factor_ff};

   assign phase_sum  = phase_ff + {1'b0, step_ff};
   assign step_wide  = {{OUT_STEP_BITS{1'b0}}, step_ff};
   assign out_busy   = rsp_valid_ff && !rsp_ch.ready;

   assign req_ch.ready = (op == OP_IDLE);

   assign status.wait_in    = !(req_ch.valid && req_ch.ready);
   assign status.depth_zero = (cur_depth == '0);
   assign status.neg        = cur_neg;
   assign status.iter_more  = (count_ff != '0);
   assign status.stage_a    = !stage_ff;
   assign status.out_busy   = out_busy;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.wrap_trigger = wrap_trigger_ff;
   assign rsp_ch.phase_step   = phase_step_ff;

   always_comb begin
      base_step_in    = base_step_ff;
      mod1_depth_in   = mod1_depth_ff;
      mod2_depth_in   = mod2_depth_ff;
      phase_in        = phase_ff;
      step_in         = step_ff;
      fmod_a_in       = fmod_a_ff;
      fmod_b_in       = fmod_b_ff;
      phase_reset_in  = phase_reset_ff;
      stage_in        = stage_ff;
      factor_in       = factor_ff;
      prod_in         = prod_ff;
      rem_in          = rem_ff;
      quot_in         = quot_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff;
      wrap_trigger_in = wrap_trigger_ff;
      phase_step_in   = phase_step_ff;

      if (csr_write) begin
         case (reg_idx)
            REG_BASE_STEP:  base_step_in  = pwdata[BASE_BITS-1:0];
            REG_MOD1_DEPTH: mod1_depth_in = pwdata[DEPTH_BITS-1:0];
            REG_MOD2_DEPTH: mod2_depth_in = pwdata[DEPTH_BITS-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (op)
         OP_IDLE: begin
            if (req_ch.valid) begin
               step_in        = base_sat;
               fmod_a_in      = req_ch.fmod_a;
               fmod_b_in      = req_ch.fmod_b;
               phase_reset_in = req_ch.phase_reset;
               stage_in       = 1'b0;
            end
         end
         OP_FACTOR: begin
            factor_in = FACTOR_ONE + FACTOR_BITS'(cur_depth) * FACTOR_BITS'(cur_mag);
         end
         OP_MUL: begin
            prod_in = PROD_BITS'(step_ff) * PROD_BITS'(factor_ff);
         end
         OP_MULSAT: begin
            step_in = mul_sat;
         end
         OP_DIVINIT: begin
            rem_in   = REM_BITS'(dividend[DVD_BITS-1:PHASE_BITS]);
            quot_in  = dividend[PHASE_BITS-1:0];
            count_in = CNT_BITS'(PHASE_BITS - 1);
         end
         OP_DIVSTEP: begin
            if (trial_fits) begin
               rem_in  = trial - {1'b0, factor_ff};
               quot_in = {quot_ff[PHASE_BITS-2:0], 1'b1};
            end else begin
               rem_in  = trial;
               quot_in = {quot_ff[PHASE_BITS-2:0], 1'b0};
            end
            count_in = count_ff - CNT_BITS'(1);
         end
         OP_DIVEND: begin
            step_in = quot_ff;
         end
         OP_SWITCH: begin
            stage_in = 1'b1;
         end
         OP_FINISH: begin
            if (!out_busy) begin
               rsp_valid_in  = 1'b1;
               phase_step_in = step_wide[OUT_STEP_BITS-1:0];
               if (phase_reset_ff) begin
                  phase_in        = '0;
                  wrap_trigger_in = 1'b1;
               end else if (phase_sum[PHASE_BITS]) begin
                  phase_in        = {1'b0, phase_sum[PHASE_BITS-1:0]};
                  wrap_trigger_in = 1'b1;
               end else begin
                  phase_in        = phase_sum;
                  wrap_trigger_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_step_ff  <= '0;
         mod1_depth_ff <= '0;
         mod2_depth_ff <= '0;
         phase_ff      <= PHASE_INIT;
         stage_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         base_step_ff  <= base_step_in;
         mod1_depth_ff <= mod1_depth_in;
         mod2_depth_ff <= mod2_depth_in;
         phase_ff      <= phase_in;
         stage_ff      <= stage_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff         <= step_in;
      fmod_a_ff       <= fmod_a_in;
      fmod_b_ff       <= fmod_b_in;
      phase_reset_ff  <= phase_reset_in;
      factor_ff       <= factor_in;
      prod_ff         <= prod_in;
      rem_ff          <= rem_in;
      quot_ff         <= quot_in;
      count_ff        <= count_in;
      wrap_trigger_ff <= wrap_trigger_in;
      phase_step_ff   <= phase_step_in;
   end

endmodule

@@ design/mpc_check.sv @@
// Port-level assertion checker for the modulated phase clock and its bind.
module mpc_check
   import mpc_pkg::*;
   (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     wrap_trigger,
   input logic [OUT_STEP_BITS-1:0] phase_step
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input side stayed ready right after a transfer");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while no tick was in work");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(phase_step) && $stable(wrap_trigger))
      else $error("stalled result changed or vanished");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind modulated_phase_clock_top mpc_check u_mpc_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .wrap_trigger (rsp_ch.wrap_trigger),
   .phase_step   (rsp_ch.phase_step)
);

@@ tb/sv/modulated_phase_clock_top_tb.sv @@
// Self-checking testbench of the modulated phase clock: ticks, register settings, result checks.
`timescale 1ns / 100ps

module modulated_phase_clock_top_tb;
   import mpc_pkg::*;

   localparam int          PHASE_W     = 24;
   localparam logic [63:0] CIRCLE      = 64'd1 << PHASE_W;
   localparam int          CYCLE_LIMIT = 500000;
   localparam int          RAND_PHASES = 6;
   localparam int          PHASE_TICKS = 100;

   typedef struct packed {
      logic                        phase_reset;
      logic signed [FMOD_BITS-1:0] fmod_a;
      logic signed [FMOD_BITS-1:0] fmod_b;
   } tick_type;

   typedef struct packed {
      logic                     wrap_trigger;
      logic [OUT_STEP_BITS-1:0] phase_step;
   } tick_result_type;

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   mpc_req_if req_ch ();
   mpc_rsp_if rsp_ch ();

   modulated_phase_clock_top #(.PHASE_BITS(PHASE_W)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   tick_type              tick_queue[$];
   tick_result_type       pending_results[$];
   logic [BASE_BITS-1:0]  cfg_base;
   logic [DEPTH_BITS-1:0] cfg_depth_a;
   logic [DEPTH_BITS-1:0] cfg_depth_b;
   logic [PHASE_W:0]      acc_phase;
   logic                  req_taken;
   logic                  calm;
   int                    cycle_count;
   int                    ticks_queued;
   int                    ticks_accepted;
   int                    results_seen;
   int                    triggers_seen;
   int                    settings_used;
   int                    fail_count;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic [63:0] clamp_step(input logic [63:0] step);
      return (step > CIRCLE - 1) ? CIRCLE - 1 : step;
   endfunction

   function automatic logic [63:0] modulate_step(input logic [63:0] step,
                                                 input logic [DEPTH_BITS-1:0] depth,
                                                 input logic [FMOD_BITS-1:0] raw);
      logic [63:0] mag;
      logic [63:0] factor;
      if (depth == '0) begin
         return step;
      end
      mag    = raw[FMOD_BITS-1] ? (64'h10000 - 64'(raw)) : 64'(raw);
      factor = (64'd1 << FRAC_BITS) + 64'(depth) * mag;
      if (raw[FMOD_BITS-1]) begin
         return clamp_step((step << FRAC_BITS) / factor);
      end
      return clamp_step((step * factor) >> FRAC_BITS);
   endfunction

   function automatic tick_result_type advance_phase(input tick_type t);
      logic [63:0]     step;
      logic [63:0]     next_phase;
      tick_result_type r;
      step       = clamp_step(64'(cfg_base));
      step       = modulate_step(step, cfg_depth_a, t.fmod_a);
      step       = modulate_step(step, cfg_depth_b, t.fmod_b);
      next_phase = 64'(acc_phase) + step;
      r.wrap_trigger = 1'b0;
      if (next_phase >= CIRCLE) begin
         next_phase     = next_phase - CIRCLE;
         r.wrap_trigger = 1'b1;
      end
      if (t.phase_reset) begin
         next_phase     = '0;
         r.wrap_trigger = 1'b1;
      end
      acc_phase    = next_phase[PHASE_W:0];
      r.phase_step = step[OUT_STEP_BITS-1:0];
      return r;
   endfunction

   function automatic logic [FMOD_BITS-1:0] rand_fmod();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return FMOD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [DEPTH_BITS-1:0] rand_depth();
      case ($urandom_range(4))
         0: return '0;
         1: return DEPTH_BITS'(61440);
         2: return DEPTH_BITS'(4096);
         default: return DEPTH_BITS'($urandom_range(61440));
      endcase
   endfunction

   function automatic logic [BASE_BITS-1:0] rand_base();
      case ($urandom_range(5))
         0: return '0;
         1: return 24'hFFFFFF;
         2: return BASE_BITS'($urandom_range(255));
         default: return BASE_BITS'($urandom);
      endcase
   endfunction

   task automatic queue_tick(input logic rst, input logic [FMOD_BITS-1:0] a,
                             input logic [FMOD_BITS-1:0] b);
      tick_queue.push_back('{rst, a, b});
      ticks_queued++;
   endtask

   task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      case (idx)
         REG_BASE_STEP:  cfg_base    = value[BASE_BITS-1:0];
         REG_MOD1_DEPTH: cfg_depth_a = value[DEPTH_BITS-1:0];
         REG_MOD2_DEPTH: cfg_depth_b = value[DEPTH_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_config(input logic [BASE_BITS-1:0] base,
                             input logic [DEPTH_BITS-1:0] depth_a,
                             input logic [DEPTH_BITS-1:0] depth_b);
      write_reg(REG_BASE_STEP, CSR_DATA_BITS'(base));
      write_reg(REG_MOD1_DEPTH, CSR_DATA_BITS'(depth_a));
      write_reg(REG_MOD2_DEPTH, CSR_DATA_BITS'(depth_b));
      settings_used++;
   endtask

   task automatic wait_drained();
      while (tick_queue.size() != 0 || ticks_accepted != ticks_queued ||
             pending_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (tick_queue.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
            req_ch.valid <= 1'b1;
            {req_ch.phase_reset, req_ch.fmod_a, req_ch.fmod_b} <= tick_queue.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && (calm || $urandom_range(99) >= 30);
   end

   always @(posedge clock) begin : check_results
      tick_result_type got;
      tick_result_type want;
      cycle_count++;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            ticks_accepted++;
            pending_results.push_back(advance_phase('{req_ch.phase_reset, req_ch.fmod_a,
                                                     req_ch.fmod_b}));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.wrap_trigger, rsp_ch.phase_step};
            results_seen++;
            if (got.wrap_trigger) begin
               triggers_seen++;
            end
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected transfer, trigger %0d step %06h",
                        $time, got.wrap_trigger, got.phase_step);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.wrap_trigger !== want.wrap_trigger) begin
                  $display("%0t: wrap_trigger expected %0d, actual %0d",
                           $time, want.wrap_trigger, got.wrap_trigger);
                  fail_count++;
               end
               if (got.phase_step !== want.phase_step) begin
                  $display("%0t: phase_step expected %06h, actual %06h",
                           $time, want.phase_step, got.phase_step);
                  fail_count++;
               end
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d results still expected",
                  $time, cycle_count, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_ch.valid       = 1'b0;
      req_ch.phase_reset = 1'b0;
      req_ch.fmod_a      = '0;
      req_ch.fmod_b      = '0;
      rsp_ch.ready       = 1'b0;
      cfg_base       = '0;
      cfg_depth_a    = '0;
      cfg_depth_b    = '0;
      acc_phase      = CIRCLE[PHASE_W:0];
      req_taken      = 1'b0;
      calm           = 1'b0;
      cycle_count    = 0;
      ticks_queued   = 0;
      ticks_accepted = 0;
      results_seen   = 0;
      triggers_seen  = 0;
      settings_used  = 1;
      fail_count     = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The phase starts at a full circle, so the first tick triggers even with a zero step.
      queue_tick(1'b0, 16'h0000, 16'h0000);
      queue_tick(1'b0, 16'h7FFF, 16'h8000);
      wait_drained();

      set_config(24'hFFFFFF, DEPTH_BITS'(61440), DEPTH_BITS'(61440));
      queue_tick(1'b0, 16'h7FFF, 16'h7FFF);
      queue_tick(1'b0, 16'h8000, 16'h8000);
      queue_tick(1'b0, 16'h8000, 16'h7FFF);
      queue_tick(1'b0, 16'h7FFF, 16'h8000);
      queue_tick(1'b1, 16'h7FFF, 16'h7FFF);
      queue_tick(1'b0, 16'h0000, 16'h0000);
      queue_tick(1'b0, 16'hFFFF, 16'h0001);
      queue_tick(1'b1, 16'h0000, 16'h0000);
      wait_drained();

      set_config(24'h000001, DEPTH_BITS'(4096), '0);
      queue_tick(1'b0, 16'h7FFF, 16'h8000);
      queue_tick(1'b0, 16'h8000, 16'h7FFF);
      queue_tick(1'b0, 16'h0000, 16'h0000);
      queue_tick(1'b0, 16'h4000, 16'hC000);
      wait_drained();

      set_config(24'h800000, '0, '0);
      queue_tick(1'b0, 16'h0000, 16'h0000);
      queue_tick(1'b0, 16'h0000, 16'h0000);
      queue_tick(1'b0, 16'h7FFF, 16'h8000);
      queue_tick(1'b0, 16'h5555, 16'hAAAA);
      wait_drained();

      for (int p = 0; p < RAND_PHASES; p++) begin
         set_config(rand_base(), rand_depth(), rand_depth());
         calm = (p == 3);
         for (int i = 0; i < PHASE_TICKS; i++) begin
            queue_tick($urandom_range(99) < 6, rand_fmod(), rand_fmod());
         end
         wait_drained();
      end
      calm = 1'b0;

      repeat (100) @(negedge clock);
      $display("Covered %0d ticks under %0d register settings, %0d results with %0d triggers.",
               ticks_accepted, settings_used, results_seen, triggers_seen);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches found.", fail_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
